[hdl/timestamp_kway_merge_assert.svh]
// Assertion macros for the timestamp k-way merge block.
// Included by the top level; depends on nothing else.
`ifndef TIMESTAMP_KWAY_MERGE_ASSERT_SVH
`define TIMESTAMP_KWAY_MERGE_ASSERT_SVH

// Same-cycle implication check.
`define KWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kwm same-cycle check failed");

// Next-cycle implication check.
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kwm next-cycle check failed");

`endif

[hdl/kwm_pkg.sv]
// Shared constants, codes and item structs of the timestamp k-way merge.
// Used by every module of the block; depends on nothing.
package kwm_pkg;

   localparam int SOURCES    = 8;
   localparam int SRC_W      = $clog2(SOURCES);
   localparam int LEAVES     = 1 << SRC_W;
   localparam int NCNT_W     = $clog2(SOURCES + 1);
   localparam int CFG_W      = 4;
   localparam int SRCF_W     = 3;
   localparam int TS_W       = 64;
   localparam int TAG_W      = 32;
   localparam int FEED_W     = 64;
   localparam int CNT_W      = 32;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 200;
   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

   typedef enum logic {
      CMD_RECORD = 1'b0,
      CMD_END    = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_RECORD = 1'b0,
      KIND_FINISH = 1'b1
   } kind_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [SRCF_W-1:0]   source;
      logic [TS_W-1:0]     timestamp;
      logic [TAG_W-1:0]    record_tag;
      logic [FEED_W-1:0]   feed_id;
   } req_item_type;

   typedef struct packed {
      kind_type            kind;
      logic [SRCF_W-1:0]   out_source;
      logic [TS_W-1:0]     out_timestamp;
      logic [TAG_W-1:0]    out_tag;
      logic [FEED_W-1:0]   out_feed_id;
      logic [CNT_W-1:0]    merged_count;
   } rsp_item_type;

endpackage

[hdl/kwm_min_tree.sv]
// Compare tree that finds the valid head with the smallest timestamp.
// Ties go to the lower source index. Depends on kwm_pkg.
module kwm_min_tree
   import kwm_pkg::*;
(
   input  logic                 leaf_valid [SOURCES],
   input  logic [TS_W-1:0]      leaf_ts    [SOURCES],
   output logic                 found,
   output logic [SRC_W-1:0]     best
);

   logic             node_valid [1:2*LEAVES-1];
   logic [TS_W-1:0]  node_ts    [1:2*LEAVES-1];
   logic [SRC_W-1:0] node_idx   [1:2*LEAVES-1];

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < SOURCES) begin
            node_valid[LEAVES + i] = leaf_valid[i];
            node_ts[LEAVES + i]    = leaf_ts[i];
         end else begin
            node_valid[LEAVES + i] = 1'b0;
            node_ts[LEAVES + i]    = '0;
         end
         node_idx[LEAVES + i] = SRC_W'(i);
      end
      for (int k = LEAVES - 1; k >= 1; k--) begin
         if (node_valid[2*k] && (!node_valid[2*k+1] || node_ts[2*k] <= node_ts[2*k+1])) begin
            node_valid[k] = 1'b1;
            node_ts[k]    = node_ts[2*k];
            node_idx[k]   = node_idx[2*k];
         end else begin
            node_valid[k] = node_valid[2*k+1];
            node_ts[k]    = node_ts[2*k+1];
            node_idx[k]   = node_idx[2*k+1];
         end
      end
   end

   assign found = node_valid[1];
   assign best  = node_idx[1];

endmodule

[hdl/kwm_core.sv]
// Head registers, merge decision and emitted count of the k-way merge.
// Depends on kwm_pkg and kwm_min_tree.
module kwm_core
   import kwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  req_item_type       item,
   input  logic [CFG_W-1:0]   active_sources,
   output logic               res_valid,
   output rsp_item_type       res
);

   logic              head_valid_ff  [SOURCES];
   logic              head_valid_in  [SOURCES];
   logic              ended_ff       [SOURCES];
   logic              ended_in       [SOURCES];
   logic [TS_W-1:0]   head_time_ff   [SOURCES];
   logic [TAG_W-1:0]  head_handle_ff [SOURCES];
   logic [FEED_W-1:0] head_feed_ff   [SOURCES];
   logic [CNT_W-1:0]  total_ff;
   logic [CNT_W-1:0]  total_in;

   logic              eff_valid  [SOURCES];
   logic              tree_valid [SOURCES];
   logic [TS_W-1:0]   eff_ts     [SOURCES];
   logic [NCNT_W-1:0] live_n;
   logic [SRC_W-1:0]  idx;
   logic              in_range;
   logic              wr;
   logic              found;
   logic [SRC_W-1:0]  best;
   logic              all_ready;
   logic              all_done;

   always_comb begin
      if (active_sources == '0) begin
         live_n = NCNT_W'(1);
      end else if (32'(active_sources) > SOURCES) begin
         live_n = NCNT_W'(SOURCES);
      end else begin
         live_n = NCNT_W'(active_sources);
      end
      in_range = 32'(item.source) < 32'(live_n);
      idx      = SRC_W'(item.source);
      wr       = in_range && item.cmd == CMD_RECORD && !head_valid_ff[idx] && !ended_ff[idx];
      for (int i = 0; i < SOURCES; i++) begin
         eff_valid[i]  = head_valid_ff[i] || (wr && idx == SRC_W'(i));
         tree_valid[i] = eff_valid[i] && (i < int'(live_n));
         eff_ts[i]     = (wr && idx == SRC_W'(i)) ? item.timestamp : head_time_ff[i];
         ended_in[i]   = ended_ff[i] || (in_range && item.cmd == CMD_END && idx == SRC_W'(i));
      end
   end

   kwm_min_tree u_min_tree (
      .leaf_valid (tree_valid),
      .leaf_ts    (eff_ts),
      .found      (found),
      .best       (best)
   );

   always_comb begin
      all_ready = 1'b1;
      all_done  = 1'b1;
      for (int i = 0; i < SOURCES; i++) begin
         if (i < int'(live_n)) begin
            if (!eff_valid[i] && !ended_in[i]) all_ready = 1'b0;
            if (eff_valid[i] || !ended_in[i]) all_done = 1'b0;
         end
      end
   end

   always_comb begin
      head_valid_in = eff_valid;
      total_in      = total_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (all_done) begin
         res_valid        = 1'b1;
         res.kind         = KIND_FINISH;
         res.merged_count = total_ff;
         total_in         = '0;
         for (int i = 0; i < SOURCES; i++) head_valid_in[i] = 1'b0;
      end else if (all_ready && found) begin
         if (total_ff != '1) total_in = total_ff + CNT_W'(1);
         head_valid_in[best] = 1'b0;
         res_valid           = 1'b1;
         res.kind            = KIND_RECORD;
         res.out_source      = SRCF_W'(best);
         res.out_timestamp   = eff_ts[best];
         res.out_tag         = (wr && idx == best) ? item.record_tag : head_handle_ff[best];
         res.out_feed_id     = (wr && idx == best) ? item.feed_id : head_feed_ff[best];
         res.merged_count    = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int i = 0; i < SOURCES; i++) begin
            head_valid_ff[i] <= 1'b0;
            ended_ff[i]      <= 1'b0;
         end
      end else if (fire) begin
         total_ff <= total_in;
         for (int i = 0; i < SOURCES; i++) begin
            head_valid_ff[i] <= head_valid_in[i];
            ended_ff[i]      <= all_done ? 1'b0 : ended_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr) begin
         head_time_ff[idx]   <= item.timestamp;
         head_handle_ff[idx] <= item.record_tag;
         head_feed_ff[idx]   <= item.feed_id;
      end
   end

endmodule

[hdl/timestamp_kway_merge.sv]
// Top level of the timestamp k-way merge: input register, merge core, result register.
// Depends on kwm_pkg, kwm_core and timestamp_kway_merge_assert.svh.
//
//   channel   direction   carries
//   req_*     in          one record or end mark per item
//   rsp_*     out         one merged record or finish per result
//   csr_*     in          active_sources register write
//
// An item is merged while it sits in the input register and its result is
// registered in the result register as the item leaves. One item per cycle
// is sustained while rsp_tready stays high; the eight-way compare tree over
// the head registers sets the cycle. Reset clears all heads, end marks, the
// count and the valid flags. A stalled result holds the input register,
// which then back-pressures req_tready.
`include "timestamp_kway_merge_assert.svh"

module timestamp_kway_merge
   import kwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // source[2:0], timestamp[66:3], record_tag[98:67], feed_id[162:99], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_source[2:0], out_timestamp[66:3], out_tag[98:67], out_feed_id[162:99],
   // merged_count[194:163], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind[0]
   output logic                  rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data
);

   logic               in_valid_ff;
   req_item_type       in_item_ff;
   logic               out_valid_ff;
   rsp_item_type       out_item_ff;
   logic [CFG_W-1:0]   active_ff;
   logic               advance;
   logic               res_valid;
   rsp_item_type       res;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.cmd        <= cmd_type'(req_tuser);
         in_item_ff.source     <= req_tdata[2:0];
         in_item_ff.timestamp  <= req_tdata[66:3];
         in_item_ff.record_tag <= req_tdata[98:67];
         in_item_ff.feed_id    <= req_tdata[162:99];
      end
   end

   kwm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (in_item_ff),
      .active_sources (active_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.kind;
   assign rsp_tdata  = {5'b0, out_item_ff.merged_count, out_item_ff.out_feed_id,
                        out_item_ff.out_tag, out_item_ff.out_timestamp,
                        out_item_ff.out_source};

   `KWM_ASSERT_NOW(a_finish_zero, clock, reset,
      out_valid_ff && out_item_ff.kind == KIND_FINISH,
      out_item_ff.out_source == '0 && out_item_ff.out_timestamp == '0 &&
      out_item_ff.out_tag == '0 && out_item_ff.out_feed_id == '0)
   `KWM_ASSERT_NOW(a_record_counted, clock, reset,
      out_valid_ff && out_item_ff.kind == KIND_RECORD,
      out_item_ff.merged_count != '0)
   `KWM_ASSERT_NEXT(a_input_held, clock, reset,
      in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff))

endmodule
